[design/adenv_pkg.sv]
// Shared constants, types and the decay table of the attack-decay envelope generator.
package adenv_pkg;

	localparam int MAX_BLOCK   = 4096;
	localparam int EXP_ENTRIES = 256;
	localparam int PHASE_BITS  = 24;

	localparam int FUNC_W  = 2;
	localparam int BLK_W   = 13;
	localparam int LEVEL_W = 16;
	localparam int STAGE_W = 2;
	localparam int TIME_W  = 16;
	localparam int RATE_W  = 18;
	localparam int CIDX_W  = 2;
	localparam int CDATA_W = 18;
	localparam int PROD_W  = TIME_W + RATE_W;
	localparam int LEN_W   = 25;
	localparam int KDIV_W  = 10;
	localparam int EXP_BITS = $clog2(EXP_ENTRIES);
	localparam int CNT_W   = $clog2(PROD_W);

	localparam logic [KDIV_W-1:0] MS_PER_S = KDIV_W'(1000);

	localparam logic [TIME_W-1:0] ATTACK_RST = TIME_W'(10);
	localparam logic [TIME_W-1:0] DECAY_RST  = TIME_W'(200);
	localparam logic [RATE_W-1:0] RATE_RST   = RATE_W'(48000);
	localparam logic [LEN_W-1:0]  LEN_A_RST  = LEN_W'(10 * 48000 / 1000);
	localparam logic [LEN_W-1:0]  LEN_D_RST  = LEN_W'(200 * 48000 / 1000);

	localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(32768);

	localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_TRIGGER = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;

	localparam logic [CIDX_W-1:0] CFG_ATTACK = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_DECAY  = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_RATE   = 2'd2;

	typedef enum logic [STAGE_W-1:0] {
		STAGE_IDLE   = 2'd0,
		STAGE_ATTACK = 2'd1,
		STAGE_DECAY  = 2'd2
	} stage_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_MUL,
		FSM_DIVK,
		FSM_STEP,
		FSM_FIN
	} fsm_state_t;

	typedef logic [EXP_ENTRIES-1:0][LEVEL_W-1:0] exp_rom_t;

	// Taylor series of exp(-t/16) in Q31, squared four times, rounded to Q1.15.
	function automatic exp_rom_t build_exp_rom();
		exp_rom_t    rom;
		logic [63:0] u;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] e;
		for (int i = 0; i < EXP_ENTRIES; i++) begin
			u = (64'(i) << 31) / (4 * EXP_ENTRIES);
			term = 64'd1 << 31;
			sum = 64'd1 << 31;
			for (int k = 1; k <= 10; k++) begin
				term = ((term * u) >> 31) / 64'(k);
				if ((k % 2) == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			e = sum;
			for (int s = 0; s < 4; s++) begin
				e = (e * e + (64'd1 << 30)) >> 31;
			end
			e = (e + (64'd1 << 15)) >> 16;
			if (e > 64'd32768) begin
				e = 64'd32768;
			end
			rom[i] = e[LEVEL_W-1:0];
		end
		return rom;
	endfunction

	localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

[design/ad_envelope_generator_unit.sv]
// Attack-decay envelope generator with bit-serial length and phase-step arithmetic.
// Trigger, clear, idle advance and saturated steps pass from acceptance through the finish
// state to the output register; an advance in a running stage first runs 24 restoring-division steps.
// One transaction at a time: the next is accepted only after the result is loaded.
// A configuration write recomputes both stage lengths, inputs held off.
// Reset clears the envelope state and preloads the lengths for the reset register values.
module ad_envelope_generator_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [adenv_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [adenv_pkg::CDATA_W-1:0]   cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [adenv_pkg::FUNC_W-1:0]    func,
	input  logic [adenv_pkg::BLK_W-1:0]     block_count,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [adenv_pkg::LEVEL_W-1:0]   level,
	output logic [adenv_pkg::STAGE_W-1:0]   stage
);
	import adenv_pkg::*;

	fsm_state_t state_q, state_d;

	logic [TIME_W-1:0]  attack_q, decay_q;
	logic [RATE_W-1:0]  rate_q;
	logic               dirty_q;
	logic               sel_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [TIME_W-1:0]  mplr_q;
	logic [PROD_W-1:0]  div_q, div_next;
	logic [KDIV_W-1:0]  remk_q, remk_next;
	logic [KDIV_W:0]    remk_try;
	logic               kge;
	logic [LEN_W-1:0]   len_a_q, len_d_q, len_new, len_cur;

	stage_t                 stage_q;
	logic [PHASE_BITS-1:0]  phase_q;
	logic [LEVEL_W-1:0]     lvl_q;

	logic [FUNC_W-1:0]      func_q;
	logic                   sat_q;
	logic [LEN_W-1:0]       rem_q, rem_next;
	logic [LEN_W:0]         rem_try;
	logic                   sge;
	logic [PHASE_BITS-1:0]  quo_q;
	logic [BLK_W-1:0]       blk;
	logic                   running, blk_ge, needs_div;
	logic [PHASE_BITS:0]    step, sum;

	logic                   out_valid_q;
	logic [LEVEL_W-1:0]     level_q;
	stage_t                 ostage_q;

	logic                   in_fire, cfg_fire, start_cal, slot_free, out_load;
	stage_t                 stage_n;
	logic [PHASE_BITS-1:0]  phase_n;
	logic [LEVEL_W-1:0]     lvl_n;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;
	assign in_fire   = in_valid & in_ready;
	assign slot_free = ~out_valid_q | out_ready;

	assign blk       = (block_count > BLK_W'(MAX_BLOCK)) ? BLK_W'(MAX_BLOCK) : block_count;
	assign running   = (stage_q != STAGE_IDLE);
	assign len_cur   = (stage_q == STAGE_DECAY) ? len_d_q : len_a_q;
	assign blk_ge    = (LEN_W'(blk) >= len_cur);
	assign needs_div = (func == FUNC_ADVANCE) && running && !blk_ge;

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (dirty_q) begin
					state_d = FSM_MUL;
				end else if (in_valid) begin
					state_d = needs_div ? FSM_STEP : FSM_FIN;
				end
			end
			FSM_MUL: begin
				if (cnt_q == '0) begin
					state_d = FSM_DIVK;
				end
			end
			FSM_DIVK: begin
				if (cnt_q == '0) begin
					state_d = sel_q ? FSM_IDLE : FSM_MUL;
				end
			end
			FSM_STEP: begin
				if (cnt_q == '0) begin
					state_d = FSM_FIN;
				end
			end
			FSM_FIN: begin
				if (slot_free) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		start_cal = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				in_ready  = ~dirty_q;
				start_cal = dirty_q;
			end
			FSM_FIN:  out_load = slot_free;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q <= ATTACK_RST;
			decay_q  <= DECAY_RST;
			rate_q   <= RATE_RST;
			dirty_q  <= 1'b0;
		end else begin
			if (cfg_fire) begin
				case (cfg_index)
					CFG_ATTACK: attack_q <= cfg_data[TIME_W-1:0];
					CFG_DECAY:  decay_q  <= cfg_data[TIME_W-1:0];
					CFG_RATE:   rate_q   <= cfg_data[RATE_W-1:0];
					default:    rate_q   <= rate_q;
				endcase
			end
			dirty_q <= cfg_fire | (dirty_q & ~start_cal);
		end
	end

	// Stage length: serial multiply of time by rate, then serial division by 1000.
	assign div_next = (state_q == FSM_MUL)
		? ({div_q[PROD_W-2:0], 1'b0} + (mplr_q[TIME_W-1] ? PROD_W'(rate_q) : '0))
		: {div_q[PROD_W-2:0], kge};
	assign remk_try  = {remk_q, div_q[PROD_W-1]};
	assign kge       = (remk_try >= (KDIV_W+1)'(MS_PER_S));
	assign remk_next = kge ? KDIV_W'(remk_try - (KDIV_W+1)'(MS_PER_S)) : remk_try[KDIV_W-1:0];
	assign len_new   = (div_next[LEN_W-1:0] == '0) ? LEN_W'(1) : div_next[LEN_W-1:0];

	// Phase step: restoring division of the block count by the stage length.
	assign rem_try  = {rem_q, 1'b0};
	assign sge      = (rem_try >= (LEN_W+1)'(len_cur));
	assign rem_next = sge ? LEN_W'(rem_try - (LEN_W+1)'(len_cur)) : rem_try[LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q   <= 1'b0;
			cnt_q   <= '0;
			len_a_q <= LEN_A_RST;
			len_d_q <= LEN_D_RST;
		end else begin
			case (state_q)
				FSM_IDLE: begin
					if (start_cal) begin
						sel_q <= 1'b0;
						cnt_q <= CNT_W'(TIME_W - 1);
					end else if (in_fire) begin
						cnt_q <= CNT_W'(PHASE_BITS - 1);
					end
				end
				FSM_MUL: begin
					cnt_q <= (cnt_q == '0) ? CNT_W'(PROD_W - 1) : cnt_q - 1'b1;
				end
				FSM_DIVK: begin
					if (cnt_q == '0) begin
						if (sel_q) begin
							len_d_q <= len_new;
						end else begin
							len_a_q <= len_new;
						end
						sel_q <= 1'b1;
						cnt_q <= CNT_W'(TIME_W - 1);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				FSM_STEP: begin
					cnt_q <= cnt_q - 1'b1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			FSM_IDLE: begin
				mplr_q <= attack_q;
				div_q  <= '0;
				func_q <= func;
				sat_q  <= blk_ge;
				rem_q  <= LEN_W'(blk);
				quo_q  <= '0;
			end
			FSM_MUL: begin
				mplr_q <= {mplr_q[TIME_W-2:0], 1'b0};
				div_q  <= div_next;
				remk_q <= '0;
			end
			FSM_DIVK: begin
				div_q  <= (cnt_q == '0) ? '0 : div_next;
				remk_q <= remk_next;
				mplr_q <= decay_q;
			end
			FSM_STEP: begin
				rem_q <= rem_next;
				quo_q <= {quo_q[PHASE_BITS-2:0], sge};
			end
			default: begin
				quo_q <= quo_q;
			end
		endcase
	end

	assign step = sat_q ? {1'b1, {PHASE_BITS{1'b0}}} : {1'b0, quo_q};
	assign sum  = {1'b0, phase_q} + step;

	always_comb begin
		stage_n = stage_q;
		phase_n = phase_q;
		lvl_n   = lvl_q;
		case (func_q)
			FUNC_TRIGGER: begin
				stage_n = STAGE_ATTACK;
				phase_n = '0;
			end
			FUNC_CLEAR: begin
				stage_n = STAGE_IDLE;
				phase_n = '0;
				lvl_n   = '0;
			end
			FUNC_ADVANCE: begin
				case (stage_q)
					STAGE_ATTACK: begin
						if (sum[PHASE_BITS]) begin
							stage_n = STAGE_DECAY;
							phase_n = '0;
							lvl_n   = LEVEL_FULL;
						end else begin
							phase_n = sum[PHASE_BITS-1:0];
							lvl_n   = {1'b0, sum[PHASE_BITS-1 -: LEVEL_W-1]};
						end
					end
					STAGE_DECAY: begin
						if (sum[PHASE_BITS]) begin
							stage_n = STAGE_IDLE;
							phase_n = '0;
							lvl_n   = '0;
						end else begin
							phase_n = sum[PHASE_BITS-1:0];
							lvl_n   = EXP_ROM[sum[PHASE_BITS-1 -: EXP_BITS]];
						end
					end
					default: begin
						stage_n = stage_q;
					end
				endcase
			end
			default: begin
				stage_n = stage_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q     <= STAGE_IDLE;
			phase_q     <= '0;
			lvl_q       <= '0;
			out_valid_q <= 1'b0;
			ostage_q    <= STAGE_IDLE;
		end else begin
			if (out_load) begin
				stage_q     <= stage_n;
				phase_q     <= phase_n;
				lvl_q       <= lvl_n;
				out_valid_q <= 1'b1;
				ostage_q    <= stage_n;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			level_q <= lvl_n;
		end
	end

	assign out_valid = out_valid_q;
	assign level     = level_q;
	assign stage     = ostage_q;

endmodule

[design/adenv_chk.sv]
// Port-level checker for the envelope generator, bound to the top level.
module adenv_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [adenv_pkg::LEVEL_W-1:0] level,
	input logic [adenv_pkg::STAGE_W-1:0] stage
);
	import adenv_pkg::*;

	// A waiting result keeps its value until its transaction completes.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level) && $stable(stage))
		else $error("result changed while stalled");

	// One item at a time: no input transaction directly after another.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in progress");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> level <= LEVEL_FULL)
		else $error("level above full scale");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stage == STAGE_W'(STAGE_IDLE) |-> level == '0)
		else $error("idle stage with nonzero level");

endmodule

bind ad_envelope_generator_unit adenv_chk u_adenv_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.level     (level),
	.stage     (stage)
);
